@@ hw/rtl/srfp_pkg.sv @@
// Shared types and constants for the sensor response frame parser.
// Used by every module of the block; depends on nothing.
package srfp_pkg;

  localparam int unsigned MAX_BUFFER_DEF = 50;
  localparam int unsigned MIN_HEADER_DEF = 3;

  localparam logic [7:0] HEADER_RST     = 8'd22;
  localparam logic [7:0] OPEN_CLOSE_RST = 8'd12;
  localparam logic [7:0] PARTICLE_RST   = 8'd11;
  localparam logic [7:0] MASS_RST       = 8'd13;

  localparam logic [7:0] OPEN_ACK_BYTE = 8'h02;
  localparam logic [7:0] MIN_DATA_LEN  = 8'd17;
  localparam logic [7:0] MIN_ACK_LEN   = 8'd2;
  localparam int unsigned POS_W        = 9;
  localparam logic [POS_W-1:0] DATA_FIRST_POS = 9'd3;
  localparam logic [POS_W-1:0] DATA_LAST_POS  = 9'd14;
  localparam logic [POS_W-1:0] LEN_POS        = 9'd1;
  localparam logic [POS_W-1:0] CMD_POS        = 9'd2;
  localparam logic [POS_W-1:0] FIRST_DATA_POS = 9'd3;

  typedef enum logic [1:0] {
    CFG_HEADER     = 2'd0,
    CFG_OPEN_CLOSE = 2'd1,
    CFG_PARTICLE   = 2'd2,
    CFG_MASS       = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OPEN_ACK   = 3'd0,
    ST_OPEN_OTHER = 3'd1,
    ST_PARTICLE   = 3'd2,
    ST_MASS       = 3'd3,
    ST_CS_ERROR   = 3'd4,
    ST_UNKNOWN    = 3'd5
  } status_t;

  typedef struct packed {
    logic       is_header;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0] open_close_code;
    logic [7:0] particle_code;
    logic [7:0] mass_code;
  } codes_t;

endpackage

@@ hw/rtl/srfp_front.sv @@
// Front stage: registers each received item and tags it as a header byte or not.
// Depends on srfp_pkg for the queue item type.
module srfp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic [7:0]         header_byte,
  output logic               push,
  output srfp_pkg::item_t    push_item,
  input  logic               q_ready
);

  logic            valid_r, valid_nxt;
  srfp_pkg::item_t item_r;
  logic            take;

  assign push     = valid_r && q_ready;
  assign in_stall = valid_r && !q_ready;
  assign take     = in_valid && !in_stall;
  assign push_item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.data      <= in_rx_byte;
      item_r.is_header <= (in_rx_byte == header_byte);
    end
  end

endmodule

@@ hw/rtl/srfp_queue.sv @@
// Two-entry queue of tagged items between the front and back stages.
// Depends on srfp_pkg for the item type.
module srfp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  srfp_pkg::item_t push_item,
  output logic            q_ready,
  input  logic            pop,
  output logic            q_valid,
  output srfp_pkg::item_t head_item
);

  srfp_pkg::item_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  assign q_ready   = (count_r != 2'd2);
  assign q_valid   = (count_r != 2'd0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // The front never pushes into a full queue, and the back never pops an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != 2'd2))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != 2'd0))
    else $error("queue pop while empty");

endmodule

@@ hw/rtl/srfp_back.sv @@
// Back stage: walks the frame one item per cycle unless a held result is stalled,
// keeps the checksum and data words, and holds the classified result in an output register. Depends on srfp_pkg.
module srfp_back #(
  parameter int unsigned MAX_BUFFER = srfp_pkg::MAX_BUFFER_DEF,
  parameter int unsigned MIN_HEADER = srfp_pkg::MIN_HEADER_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  srfp_pkg::item_t  head_item,
  output logic             pop,
  input  srfp_pkg::codes_t codes,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_value_first,
  output logic [31:0]      out_value_second,
  output logic [31:0]      out_value_third
);

  localparam int unsigned CNT_W = $clog2(MAX_BUFFER + 1);
  localparam int unsigned PW    = srfp_pkg::POS_W;

  logic [CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [31:0]      words_r [3];

  logic             out_valid_r, out_valid_nxt;
  srfp_pkg::status_t status_r, status_nxt;
  logic [31:0]      v1_r, v2_r, v3_r, v1_nxt, v2_nxt, v3_nxt;

  logic [PW-1:0]    pos;
  logic [PW-1:0]    pos_inc;
  logic [PW-1:0]    word_off;
  logic [1:0]       word_idx;
  logic             word_wr;
  logic [7:0]       b;
  logic [7:0]       cmd_eff;
  logic             is_final;
  logic             result;

  assign pop  = q_valid && !(out_valid_r && out_stall);
  assign b    = head_item.data;
  assign pos  = PW'(byte_cnt_r);
  assign pos_inc  = pos + PW'(1);
  assign word_off = pos - srfp_pkg::DATA_FIRST_POS;
  assign word_idx = word_off[3:2];
  assign cmd_eff  = (pos == srfp_pkg::CMD_POS) ? b : cmd_r;

  assign is_final = (pos >= srfp_pkg::CMD_POS) && (pos_inc >= PW'(MIN_HEADER)) &&
                    (pos == {1'b0, len_r} + PW'(2)) &&
                    ({1'b0, len_r} + PW'(3) <= PW'(MAX_BUFFER));
  assign result   = pop && (byte_cnt_r != '0) && is_final;
  assign word_wr  = pop && (byte_cnt_r != '0) && !is_final &&
                    (pos >= srfp_pkg::DATA_FIRST_POS) && (pos <= srfp_pkg::DATA_LAST_POS);

  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    len_nxt      = len_r;
    cmd_nxt      = cmd_r;
    sum_nxt      = sum_r;
    first_nxt    = first_r;
    if (pop) begin
      if (byte_cnt_r == '0) begin
        if (head_item.is_header) begin
          sum_nxt      = b;
          byte_cnt_nxt = CNT_W'(1);
        end
      end else if (is_final) begin
        cmd_nxt      = cmd_eff;
        byte_cnt_nxt = '0;
      end else begin
        sum_nxt = sum_r + b;
        if (pos == srfp_pkg::LEN_POS) begin
          len_nxt = b;
        end
        if (pos == srfp_pkg::CMD_POS) begin
          cmd_nxt = b;
        end
        if (pos == srfp_pkg::FIRST_DATA_POS) begin
          first_nxt = b;
        end
        if (pos_inc > PW'(MAX_BUFFER)) begin
          byte_cnt_nxt = '0;
        end else begin
          byte_cnt_nxt = CNT_W'(pos_inc);
        end
      end
    end
  end

  always_comb begin
    status_nxt = srfp_pkg::ST_UNKNOWN;
    v1_nxt     = '0;
    v2_nxt     = '0;
    v3_nxt     = '0;
    if ((8'd0 - sum_r) != b) begin
      status_nxt = srfp_pkg::ST_CS_ERROR;
    end else if (cmd_eff == codes.open_close_code) begin
      if ((len_r >= srfp_pkg::MIN_ACK_LEN) && (first_r == srfp_pkg::OPEN_ACK_BYTE)) begin
        status_nxt = srfp_pkg::ST_OPEN_ACK;
      end else begin
        status_nxt = srfp_pkg::ST_OPEN_OTHER;
      end
    end else if ((cmd_eff == codes.particle_code) && (len_r >= srfp_pkg::MIN_DATA_LEN)) begin
      status_nxt = srfp_pkg::ST_PARTICLE;
      v1_nxt     = words_r[0];
      v2_nxt     = words_r[1];
      v3_nxt     = words_r[2];
    end else if ((cmd_eff == codes.mass_code) && (len_r >= srfp_pkg::MIN_DATA_LEN)) begin
      status_nxt = srfp_pkg::ST_MASS;
      v1_nxt     = words_r[0];
      v2_nxt     = words_r[1];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (result) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r  <= '0;
      len_r       <= '0;
      cmd_r       <= '0;
      sum_r       <= '0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      byte_cnt_r  <= byte_cnt_nxt;
      len_r       <= len_nxt;
      cmd_r       <= cmd_nxt;
      sum_r       <= sum_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (word_wr) begin
      words_r[word_idx] <= {words_r[word_idx][23:0], b};
    end
    if (result) begin
      status_r <= status_nxt;
      v1_r     <= v1_nxt;
      v2_r     <= v2_nxt;
      v3_r     <= v3_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_value_first  = v1_r;
  assign out_value_second = v2_r;
  assign out_value_third  = v3_r;

  // A held result is never overwritten, the count stays within the buffer limit,
  // and only a particle result carries a third value.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !result)
    else $error("result register overwritten while stalled");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= CNT_W'(MAX_BUFFER))
    else $error("byte count above buffer limit");

  a_third_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != srfp_pkg::ST_PARTICLE)) |-> (v3_r == 32'd0))
    else $error("third value set on a non-particle result");

endmodule

@@ hw/rtl/sensor_response_frame_parser.sv @@
// Sensor response frame parser: finds header-led frames in a received byte stream,
// checks the two's-complement checksum and reports one classified result per frame.
// Depends on srfp_pkg, srfp_front, srfp_queue and srfp_back.
//
// Usage: the input channel (in_valid, in_stall, in_rx_byte) carries one received byte
// per item. The result channel (out_valid, out_stall, out_status, out_value_*) carries
// one item per complete frame; frames that fail the buffer limit give none. The
// configuration port (cfg_wr_en, cfg_index, cfg_wdata) writes the header byte and the
// three command codes; write it only while the block is idle.
// Throughput is one byte per cycle while no stalled result holds the parser in the back stage.
// The checksum byte of a frame passes from the front register through the queue to the
// parser, which loads the result into the output register that drives out_valid.
// When the receiver stalls, the result holds in the output register, the queue fills
// and in_stall rises once the front register has nowhere to go.
// Reset (rst_n low at a clock edge) restores the register defaults, empties the queue
// and returns the parser to hunting for a header byte.
module sensor_response_frame_parser #(
  parameter int unsigned MAX_BUFFER = srfp_pkg::MAX_BUFFER_DEF,
  parameter int unsigned MIN_HEADER = srfp_pkg::MIN_HEADER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_value_first,
  output logic [31:0] out_value_second,
  output logic [31:0] out_value_third,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]       header_r;
  srfp_pkg::codes_t codes_r;

  logic             push;
  srfp_pkg::item_t  push_item;
  logic             q_ready;
  logic             q_valid;
  logic             pop;
  srfp_pkg::item_t  head_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r                <= srfp_pkg::HEADER_RST;
      codes_r.open_close_code <= srfp_pkg::OPEN_CLOSE_RST;
      codes_r.particle_code   <= srfp_pkg::PARTICLE_RST;
      codes_r.mass_code       <= srfp_pkg::MASS_RST;
    end else if (cfg_wr_en) begin
      case (srfp_pkg::cfg_idx_t'(cfg_index))
        srfp_pkg::CFG_HEADER:     header_r                <= cfg_wdata;
        srfp_pkg::CFG_OPEN_CLOSE: codes_r.open_close_code <= cfg_wdata;
        srfp_pkg::CFG_PARTICLE:   codes_r.particle_code   <= cfg_wdata;
        srfp_pkg::CFG_MASS:       codes_r.mass_code       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  srfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .header_byte(header_r),
    .push       (push),
    .push_item  (push_item),
    .q_ready    (q_ready)
  );

  srfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .head_item(head_item)
  );

  srfp_back #(
    .MAX_BUFFER(MAX_BUFFER),
    .MIN_HEADER(MIN_HEADER)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .head_item       (head_item),
    .pop             (pop),
    .codes           (codes_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_value_first (out_value_first),
    .out_value_second(out_value_second),
    .out_value_third (out_value_third)
  );

endmodule

@@ sim/tb_sensor_response_frame_parser.sv @@
// Testbench for sensor_response_frame_parser: sends framed and noisy byte streams under
// several register settings, sender gaps and receiver stalls, and checks each frame result.
// Depends on srfp_pkg and the parser RTL; it needs no other file.
module tb_sensor_response_frame_parser;
  import srfp_pkg::*;

  localparam int unsigned BUF_LIMIT   = MAX_BUFFER_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 10;
  localparam int unsigned SEG_BYTES   = 130;
  localparam logic [31:0] ONES        = 32'hFFFF_FFFF;

  typedef struct packed {
    status_t     st;
    logic [31:0] v1;
    logic [31:0] v2;
    logic [31:0] v3;
  } frame_result_t;

  typedef struct packed {
    logic          noise;
    logic [7:0]    len;
    logic [7:0]    cmd;
    logic          rnd;
    logic [7:0]    fill;
    logic          bad_sum;
    logic          typed;
    frame_result_t res;
  } dir_row_t;

  localparam frame_result_t NO_RES    = '{ST_UNKNOWN, 32'd0, 32'd0, 32'd0};
  localparam frame_result_t RES_ACK   = '{ST_OPEN_ACK, 32'd0, 32'd0, 32'd0};
  localparam frame_result_t RES_OTHER = '{ST_OPEN_OTHER, 32'd0, 32'd0, 32'd0};
  localparam frame_result_t RES_CS    = '{ST_CS_ERROR, 32'd0, 32'd0, 32'd0};
  localparam frame_result_t RES_MASS0 = '{ST_MASS, 32'd0, 32'd0, 32'd0};
  localparam frame_result_t RES_PART1 = '{ST_PARTICLE, ONES, ONES, ONES};

  localparam dir_row_t DIR_TAB [16] = '{
    '{1'b1, 8'd0,   8'd0,           1'b0, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b1, 8'd0,   8'd0,           1'b0, 8'hFF, 1'b0, 1'b0, NO_RES},
    '{1'b0, 8'd0,   8'd0,           1'b0, 8'h00, 1'b0, 1'b1, NO_RES},
    '{1'b0, 8'd2,   OPEN_CLOSE_RST, 1'b0, 8'h02, 1'b0, 1'b1, RES_ACK},
    '{1'b0, 8'd1,   OPEN_CLOSE_RST, 1'b0, 8'h02, 1'b0, 1'b1, RES_OTHER},
    '{1'b0, 8'd2,   OPEN_CLOSE_RST, 1'b0, 8'h02, 1'b1, 1'b1, RES_CS},
    '{1'b0, 8'd2,   OPEN_CLOSE_RST, 1'b0, 8'h03, 1'b0, 1'b1, RES_OTHER},
    '{1'b0, 8'd17,  PARTICLE_RST,   1'b0, 8'hFF, 1'b0, 1'b1, RES_PART1},
    '{1'b0, 8'd17,  MASS_RST,       1'b0, 8'h00, 1'b0, 1'b1, RES_MASS0},
    '{1'b0, 8'd16,  PARTICLE_RST,   1'b0, 8'h5A, 1'b0, 1'b1, NO_RES},
    '{1'b0, 8'd17,  8'd200,         1'b0, 8'h11, 1'b0, 1'b1, NO_RES},
    '{1'b0, 8'd0,   8'd0,           1'b0, 8'h00, 1'b1, 1'b1, RES_CS},
    '{1'b0, 8'd20,  PARTICLE_RST,   1'b1, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, 8'd47,  MASS_RST,       1'b1, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, 8'd48,  PARTICLE_RST,   1'b1, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, 8'd255, 8'd0,           1'b0, 8'h00, 1'b0, 1'b0, NO_RES}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_value_first;
  logic [31:0] out_value_second;
  logic [31:0] out_value_third;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_wdata = 8'd0;

  logic [7:0]  hdr_reg = HEADER_RST;
  logic [7:0]  oc_reg = OPEN_CLOSE_RST;
  logic [7:0]  pc_reg = PARTICLE_RST;
  logic [7:0]  mc_reg = MASS_RST;

  int unsigned fr_pos = 0;
  logic [7:0]  fr_len = 8'd0;
  logic [7:0]  fr_cmd = 8'd0;
  logic [7:0]  fr_sum = 8'd0;
  logic [7:0]  fr_first = 8'd0;
  logic [31:0] fr_words [3] = '{default: 32'd0};

  frame_result_t pending_frames [$];
  logic [7:0]    frame_data [$];
  int unsigned   mismatches = 0;
  int unsigned   cycles = 0;
  int unsigned   sent_bytes = 0;
  int unsigned   send_idle = 0;
  int unsigned   recv_stall = 0;
  int            hold_left = 0;

  sensor_response_frame_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_value_first  (out_value_first),
    .out_value_second (out_value_second),
    .out_value_third  (out_value_third),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial forever #5 clk = ~clk;

  function automatic logic parse_rx_byte(input logic [7:0] b, output frame_result_t r);
    int unsigned w;
    logic [7:0]  want_sum;
    r = NO_RES;
    if (fr_pos == 0) begin
      if (b == hdr_reg) begin
        fr_sum = b;
        fr_pos = 1;
      end
      return 1'b0;
    end
    if (fr_pos >= CMD_POS && fr_pos == fr_len + 2 && fr_len + 3 <= BUF_LIMIT) begin
      if (fr_pos == CMD_POS) fr_cmd = b;
      fr_pos = 0;
      want_sum = 8'd0 - fr_sum;
      if (b != want_sum) begin
        r.st = ST_CS_ERROR;
      end else if (fr_cmd == oc_reg) begin
        r.st = (fr_len >= MIN_ACK_LEN && fr_first == OPEN_ACK_BYTE) ? ST_OPEN_ACK
                                                                  : ST_OPEN_OTHER;
      end else if (fr_cmd == pc_reg && fr_len >= MIN_DATA_LEN) begin
        r.st = ST_PARTICLE;
        r.v1 = fr_words[0];
        r.v2 = fr_words[1];
        r.v3 = fr_words[2];
      end else if (fr_cmd == mc_reg && fr_len >= MIN_DATA_LEN) begin
        r.st = ST_MASS;
        r.v1 = fr_words[0];
        r.v2 = fr_words[1];
      end else begin
        r.st = ST_UNKNOWN;
      end
      return 1'b1;
    end
    fr_sum = fr_sum + b;
    if (fr_pos == LEN_POS) fr_len = b;
    if (fr_pos == CMD_POS) fr_cmd = b;
    if (fr_pos == FIRST_DATA_POS) fr_first = b;
    if (fr_pos >= DATA_FIRST_POS && fr_pos <= DATA_LAST_POS) begin
      w = (fr_pos - DATA_FIRST_POS) / 4;
      fr_words[w] = {fr_words[w][23:0], b};
    end
    fr_pos = fr_pos + 1;
    if (fr_pos > BUF_LIMIT) fr_pos = 0;
    return 1'b0;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic typed, input frame_result_t want);
    frame_result_t got;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
    if (parse_rx_byte(b, got)) pending_frames.insert(pending_frames.size(), typed ? want : got);
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd, input logic bad,
                            input logic typed, input frame_result_t want);
    logic [7:0] sum;
    logic [7:0] tail;
    sum = hdr_reg + len;
    send_item(hdr_reg, typed, want);
    send_item(len, typed, want);
    if (len != 8'd0) begin
      sum = sum + cmd;
      send_item(cmd, typed, want);
      foreach (frame_data[i]) begin
        sum = sum + frame_data[i];
        send_item(frame_data[i], typed, want);
      end
    end
    tail = 8'd0 - sum;
    if (bad) tail = tail + 8'(1 + $urandom_range(254));
    send_item(tail, typed, want);
  endtask

  task automatic send_random_frame();
    int unsigned k;
    logic [7:0]  len;
    logic [7:0]  cmd;
    logic        bad;
    k = $urandom_range(99);
    bad = ($urandom_range(9) == 0);
    frame_data.delete();
    if (k < 8) begin
      repeat ($urandom_range(3, 1)) send_item(8'($urandom), 1'b0, NO_RES);
      return;
    end
    if (k < 14) begin
      len = ($urandom_range(7) == 0) ? 8'($urandom_range(255, 48)) : 8'($urandom_range(56, 48));
      cmd = 8'($urandom);
    end else if (k < 26) begin
      len = 8'($urandom_range(47));
      cmd = 8'($urandom);
      bad = ($urandom_range(1) == 1);
    end else begin
      case ($urandom_range(3))
        0: begin
          cmd = oc_reg;
          len = 8'($urandom_range(6));
        end
        1: begin
          cmd = pc_reg;
          len = ($urandom_range(4) == 0) ? 8'($urandom_range(47, 12)) : 8'($urandom_range(19, 15));
        end
        2: begin
          cmd = mc_reg;
          len = ($urandom_range(4) == 0) ? 8'($urandom_range(47, 12)) : 8'($urandom_range(19, 15));
        end
        default: begin
          cmd = 8'($urandom);
          len = 8'($urandom_range(20));
        end
      endcase
    end
    for (int i = 1; i < len; i++)
      frame_data.insert(frame_data.size(),
                        (i == 1 && $urandom_range(1) == 1) ? OPEN_ACK_BYTE : 8'($urandom));
    send_frame(len, cmd, bad, 1'b0, NO_RES);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_HEADER:     hdr_reg = v;
      CFG_OPEN_CLOSE: oc_reg = v;
      CFG_PARTICLE:   pc_reg = v;
      CFG_MASS:       mc_reg = v;
      default: ;
    endcase
  endtask

  task automatic set_codes(input logic [7:0] h, input logic [7:0] o, input logic [7:0] p,
                           input logic [7:0] m);
    write_reg(CFG_HEADER, h);
    write_reg(CFG_OPEN_CLOSE, o);
    write_reg(CFG_PARTICLE, p);
    write_reg(CFG_MASS, m);
  endtask

  task automatic finish_stream();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d values %h %h %h", out_status,
                   out_value_first, out_value_second, out_value_third);
      end else begin
        want = pending_frames.pop_front();
        if (out_status !== want.st || out_value_first !== want.v1 ||
            out_value_second !== want.v2 || out_value_third !== want.v3) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected status %0d values %h %h %h, got %0d %h %h %h",
                     want.st, want.v1, want.v2, want.v3, out_status,
                     out_value_first, out_value_second, out_value_third);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned seg_start;
    logic [7:0]  code;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TAB[i]) begin
      frame_data.delete();
      if (DIR_TAB[i].noise) begin
        send_item(DIR_TAB[i].fill, 1'b0, NO_RES);
      end else begin
        for (int j = 1; j < DIR_TAB[i].len; j++)
          frame_data.insert(frame_data.size(), DIR_TAB[i].rnd ? 8'($urandom) : DIR_TAB[i].fill);
        send_frame(DIR_TAB[i].len, DIR_TAB[i].cmd, DIR_TAB[i].bad_sum, DIR_TAB[i].typed,
                   DIR_TAB[i].res);
      end
    end

    for (int seg = 0; seg < 8; seg++) begin
      finish_stream();
      case (seg)
        0: set_codes(HEADER_RST, OPEN_CLOSE_RST, PARTICLE_RST, MASS_RST);
        1: set_codes(8'h00, 8'hFF, 8'h00, 8'h80);
        2: set_codes(8'hFF, 8'h00, 8'hFF, 8'h7F);
        3: begin
          code = 8'($urandom);
          set_codes(8'($urandom), code, code, code);
        end
        4: begin
          code = 8'($urandom);
          set_codes(8'($urandom), 8'($urandom), code, code);
        end
        default: set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      send_idle  = (seg % 4 == 1) ? 60 : (seg % 4 == 3) ? 8 : 0;
      recv_stall = (seg % 4 == 2) ? 60 : (seg % 4 == 3) ? 8 : 0;
      // The receiver holds off long enough for the queue to fill and stall the input.
      if (seg == 0) hold_left = 400;
      seg_start = sent_bytes;
      while (sent_bytes - seg_start < SEG_BYTES) send_random_frame();
    end

    finish_stream();
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/srfp_pkg.sv
hw/rtl/srfp_front.sv
hw/rtl/srfp_queue.sv
hw/rtl/srfp_back.sv
hw/rtl/sensor_response_frame_parser.sv
sim/tb_sensor_response_frame_parser.sv
